// ===== hw/rtl/tmrtbl_pkg.sv =====
package tmrtbl_pkg;

	localparam int ACT_W    = 3;
	localparam int KIND_W   = 2;
	localparam int PERIOD_W = 24;
	localparam int ID_W     = 16;
	localparam int TIME_W   = 32;

	localparam int MAX_RESULTS = 16;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	localparam logic [ACT_W-1:0] ACT_TICK       = 3'd0;
	localparam logic [ACT_W-1:0] ACT_START_ONE  = 3'd1;
	localparam logic [ACT_W-1:0] ACT_START_REP  = 3'd2;
	localparam logic [ACT_W-1:0] ACT_CANCEL     = 3'd3;
	localparam logic [ACT_W-1:0] ACT_CANCEL_ALL = 3'd4;

	localparam logic [KIND_W-1:0] KIND_STARTED = 2'd0;
	localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REJECT  = 2'd2;

	typedef struct packed {
		logic                rpt;
		logic [PERIOD_W-1:0] period;
		logic [TIME_W-1:0]   deadline;
		logic [ID_W-1:0]     id;
	} tmrtbl_ent_t;

	typedef struct packed {
		logic accept;
		logic rd_en;
		logic eval;
		logic flush;
	} tmrtbl_cmd_t;

	typedef struct packed {
		logic stall;
		logic flush_any;
		logic out_free;
	} tmrtbl_sts_t;

endpackage

// ===== hw/rtl/timer_table_one_shot_repeating.sv =====
// channel  dir  tdata                          tuser        tlast
// s_axis   in   period_ticks[23:0], target_id   action[2:0]  -
// m_axis   out  timer_id[15:0]                 kind[1:0]    last
//
// tick, start and cancel scan the slot store: one slot read per cycle while the scan is not stalled
// cancel-all and unused action codes do not start a scan
// a tick with many expiries stalls the scan while the output word is not taken
// reset clears all slots, the time counter and the id counter
module timer_table_one_shot_repeating import tmrtbl_pkg::*; #(
	parameter int SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // period_ticks[23:0], target_id[39:24]
	input  logic [2:0]  s_axis_tuser,   // action[2:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // timer_id[15:0]
	output logic [1:0]  m_axis_tuser,   // kind[1:0]
	output logic        m_axis_tlast
);

	localparam int AW = $clog2(SLOTS);

	tmrtbl_cmd_t   cmd;
	tmrtbl_sts_t   sts;
	logic [AW-1:0] rd_idx;
	logic [AW-1:0] ev_idx;

	tmrtbl_ctrl #(
		.SLOTS(SLOTS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.action   (s_axis_tuser),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd),
		.rd_idx   (rd_idx),
		.ev_idx   (ev_idx)
	);

	tmrtbl_dp #(
		.SLOTS(SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.rd_idx       (rd_idx),
		.ev_idx       (ev_idx),
		.action       (s_axis_tuser),
		.period_ticks (s_axis_tdata[23:0]),
		.target_id    (s_axis_tdata[39:24]),
		.m_ready      (m_axis_tready),
		.m_valid      (m_axis_tvalid),
		.kind         (m_axis_tuser),
		.timer_id     (m_axis_tdata),
		.last         (m_axis_tlast),
		.sts          (sts)
	);

endmodule

// ===== hw/rtl/tmrtbl_ctrl.sv =====
module tmrtbl_ctrl import tmrtbl_pkg::*; #(
	parameter int SLOTS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic [ACT_W-1:0]         action,
	output logic                     in_ready,
	input  tmrtbl_sts_t              sts,
	output tmrtbl_cmd_t              cmd,
	output logic [$clog2(SLOTS)-1:0] rd_idx,
	output logic [$clog2(SLOTS)-1:0] ev_idx
);

	localparam int AW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_FLUSH = 3'b100
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   idx_q;
	logic            v_s1;
	logic [AW-1:0]   idx_s1;
	logic            accept;
	logic            issue;
	logic            advance;
	logic            scan_act;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign scan_act = (action <= ACT_CANCEL);
	assign issue    = (state_q == ST_SCAN) && (idx_q != CW'(SLOTS));
	assign advance  = !(v_s1 && sts.stall);

	always_comb begin
		cmd.accept = accept;
		cmd.rd_en  = issue && advance;
		cmd.eval   = v_s1 && advance;
		cmd.flush  = (state_q == ST_FLUSH) && sts.flush_any && sts.out_free;
	end

	assign rd_idx = idx_q[AW-1:0];
	assign ev_idx = idx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			v_s1    <= 1'b0;
			idx_s1  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && scan_act) begin
						state_q <= ST_SCAN;
						idx_q   <= '0;
						v_s1    <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (advance) begin
						v_s1   <= issue;
						idx_s1 <= idx_q[AW-1:0];
						if (issue) begin
							idx_q <= idx_q + CW'(1);
						end
					end
					if (!issue && !v_s1) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					if (!sts.flush_any || sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_idle_no_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !v_s1)
		else $error("slot evaluation pending while idle");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= CW'(SLOTS))
		else $error("scan index past table");

	a_flush_end: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |=> (state_q == ST_IDLE))
		else $error("flush did not close the item");

endmodule

// ===== hw/rtl/tmrtbl_dp.sv =====
module tmrtbl_dp import tmrtbl_pkg::*; #(
	parameter int SLOTS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  tmrtbl_cmd_t              cmd,
	input  logic [$clog2(SLOTS)-1:0] rd_idx,
	input  logic [$clog2(SLOTS)-1:0] ev_idx,
	input  logic [ACT_W-1:0]         action,
	input  logic [PERIOD_W-1:0]      period_ticks,
	input  logic [ID_W-1:0]          target_id,
	input  logic                     m_ready,
	output logic                     m_valid,
	output logic [KIND_W-1:0]        kind,
	output logic [ID_W-1:0]          timer_id,
	output logic                     last,
	output tmrtbl_sts_t              sts
);

	tmrtbl_ent_t         mem [SLOTS];
	tmrtbl_ent_t         rd_q;
	logic [SLOTS-1:0]    valid_q;
	logic [TIME_W-1:0]   time_q;
	logic [ID_W-1:0]     next_id_q;
	logic [ACT_W-1:0]    op_q;
	logic [PERIOD_W-1:0] period_q;
	logic [ID_W-1:0]     target_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                done_q;
	logic                pend_v_q;
	logic [KIND_W-1:0]   pend_kind_q;
	logic [ID_W-1:0]     pend_id_q;
	logic                out_v_q;
	logic [KIND_W-1:0]   out_kind_q;
	logic [ID_W-1:0]     out_id_q;
	logic                out_last_q;

	logic                op_tick;
	logic                op_start;
	logic                slot_v;
	logic [TIME_W-1:0]   diff;
	logic                hit;
	logic                emit;
	logic                out_free;
	logic                do_hit;
	logic                push_pend;
	logic [KIND_W-1:0]   new_kind;
	logic [ID_W-1:0]     new_id;

	assign op_tick  = (op_q == ACT_TICK);
	assign op_start = (op_q == ACT_START_ONE) || (op_q == ACT_START_REP);
	assign slot_v   = valid_q[ev_idx];
	assign diff     = time_q - rd_q.deadline;

	always_comb begin
		unique case (op_q)
			ACT_TICK:      hit = slot_v && !diff[TIME_W-1] && (cnt_q != CNT_W'(MAX_RESULTS));
			ACT_START_ONE: hit = !slot_v && !done_q;
			ACT_START_REP: hit = !slot_v && !done_q;
			ACT_CANCEL:    hit = slot_v && (rd_q.id == target_q) && !done_q;
			default:       hit = 1'b0;
		endcase
	end

	assign emit      = hit && (op_tick || op_start);
	assign out_free  = !out_v_q || m_ready;
	assign do_hit    = cmd.eval && hit;
	assign push_pend = do_hit && emit && pend_v_q;
	assign new_kind  = op_tick ? KIND_EXPIRED : KIND_STARTED;
	assign new_id    = op_tick ? rd_q.id : next_id_q;

	always_comb begin
		sts.stall     = emit && pend_v_q && !out_free;
		sts.flush_any = pend_v_q || (op_start && !done_q);
		sts.out_free  = out_free;
	end

	// slot store
	always_ff @(posedge clk) begin
		if (do_hit && op_start) begin
			mem[ev_idx] <= '{
				rpt:      (op_q == ACT_START_REP),
				period:   period_q,
				deadline: time_q + {{(TIME_W-PERIOD_W){1'b0}}, period_q},
				id:       next_id_q
			};
		end else if (do_hit && op_tick && rd_q.rpt) begin
			mem[ev_idx] <= '{
				rpt:      rd_q.rpt,
				period:   rd_q.period,
				deadline: rd_q.deadline + {{(TIME_W-PERIOD_W){1'b0}}, rd_q.period},
				id:       rd_q.id
			};
		end
		if (cmd.rd_en) begin
			rd_q <= mem[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			time_q    <= '0;
			next_id_q <= '0;
			op_q      <= ACT_TICK;
			cnt_q     <= '0;
			done_q    <= 1'b0;
			pend_v_q  <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			if (cmd.accept) begin
				op_q   <= action;
				cnt_q  <= '0;
				done_q <= 1'b0;
				if (action == ACT_TICK) begin
					time_q <= time_q + TIME_W'(1);
				end
				if (action == ACT_CANCEL_ALL) begin
					valid_q <= '0;
				end
			end
			if (do_hit) begin
				if (op_tick) begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (!rd_q.rpt) begin
						valid_q[ev_idx] <= 1'b0;
					end
				end else if (op_start) begin
					valid_q[ev_idx] <= 1'b1;
					next_id_q       <= next_id_q + ID_W'(1);
					done_q          <= 1'b1;
				end else begin
					valid_q[ev_idx] <= 1'b0;
					done_q          <= 1'b1;
				end
			end
			if (do_hit && emit) begin
				pend_v_q <= 1'b1;
			end else if (cmd.flush) begin
				pend_v_q <= 1'b0;
			end
			if (push_pend || cmd.flush) begin
				out_v_q <= 1'b1;
			end else if (m_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			period_q <= period_ticks;
			target_q <= target_id;
		end
		if (do_hit && emit) begin
			pend_kind_q <= new_kind;
			pend_id_q   <= new_id;
		end
		if (push_pend) begin
			out_kind_q <= pend_kind_q;
			out_id_q   <= pend_id_q;
			out_last_q <= 1'b0;
		end else if (cmd.flush) begin
			out_kind_q <= pend_v_q ? pend_kind_q : KIND_REJECT;
			out_id_q   <= pend_v_q ? pend_id_q : '0;
			out_last_q <= 1'b1;
		end
	end

	assign m_valid  = out_v_q;
	assign kind     = out_kind_q;
	assign timer_id = out_id_q;
	assign last     = out_last_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_RESULTS))
		else $error("expiry count past limit");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(push_pend || cmd.flush) |-> out_free)
		else $error("output word overwritten while held");

	a_id_step: assert property (@(posedge clk) disable iff (!arst_n)
		(do_hit && op_start) |=> (next_id_q == $past(next_id_q) + ID_W'(1)))
		else $error("id not advanced on start");

endmodule
